@@ rtl/mcoc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcoc_pkg: shared types and constants for the matrix chain cost block
// Holds the request and response words, the status codes, the sequencer
// states, the control word of the evaluation unit and the saturating add.
// ----------------------------------------------------------------------------
package mcoc_pkg;

   typedef struct packed {
      logic [15:0] dimension;
      logic        last_dimension;
   } mcoc_req_type;

   typedef struct packed {
      logic [63:0] min_cost;
      logic [1:0]  status;
   } mcoc_rsp_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd2;
   localparam logic [1:0] STATUS_SAT      = 2'd3;

   localparam logic [63:0] COST_MAX = {64{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIM_I,
      ST_DIM_J,
      ST_PROD,
      ST_LOOP,
      ST_DRAIN,
      ST_EMIT
   } mcoc_state_type;

   // Control word from the sequencer to the evaluation unit.
   typedef struct packed {
      logic issue;       // launch one split point into the pipeline
      logic lo_diag;     // left sub-chain is a single matrix (cost zero)
      logic hi_diag;     // right sub-chain is a single matrix (cost zero)
      logic init_best;   // start a new interval with the running minimum at max
      logic write_best;  // store the running minimum into the cost table
   } mcoc_eval_ctrl_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? COST_MAX : s[63:0];
   endfunction

endpackage

@@ rtl/mcoc_eval_unit.sv @@
// ----------------------------------------------------------------------------
// mcoc_eval_unit: split-point evaluation pipeline and cost table
// Reads the two sub-chain costs, forms the split product, adds with
// saturation and keeps the running minimum of one interval.
// ----------------------------------------------------------------------------
module mcoc_eval_unit #(
   parameter int DIM_WIDTH = 16,
   parameter int IDX_WIDTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcoc_pkg::mcoc_eval_ctrl_type   ctrl,
   input  logic [2*IDX_WIDTH-1:0]         addr_lo,
   input  logic [2*IDX_WIDTH-1:0]         addr_hi,
   input  logic [2*IDX_WIDTH-1:0]         addr_wr,
   input  logic [2*DIM_WIDTH-1:0]         outer_prod,
   input  logic [DIM_WIDTH-1:0]           split_dim,
   output logic [63:0]                    best,
   output logic                           busy
);
   import mcoc_pkg::*;

   localparam int DEPTH = 1 << (2 * IDX_WIDTH);

   logic [63:0]            cost_mem [DEPTH];

   logic [63:0]            cost_lo_ff;
   logic [63:0]            cost_hi_ff;
   logic                   lo_zero_ff;
   logic                   hi_zero_ff;
   logic                   v1_ff;
   logic [3*DIM_WIDTH-1:0] prod_ff;
   logic [63:0]            sum_ff;
   logic                   v2_ff;
   logic [63:0]            best_ff;
   logic [63:0]            cand;

   // Stage 1: registered reads of the two sub-chain costs.
   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         cost_lo_ff <= cost_mem[addr_lo];
         cost_hi_ff <= cost_mem[addr_hi];
         lo_zero_ff <= ctrl.lo_diag;
         hi_zero_ff <= ctrl.hi_diag;
      end
      if (ctrl.write_best) begin
         cost_mem[addr_wr] <= best_ff;
      end
   end

   // Stage 2: split product and the sum of the sub-chain costs.
   always_ff @(posedge clock) begin
      prod_ff <= outer_prod * split_dim;
      sum_ff  <= sat_add(lo_zero_ff ? 64'd0 : cost_lo_ff, hi_zero_ff ? 64'd0 : cost_hi_ff);
   end

   assign cand = sat_add(sum_ff, 64'(prod_ff));

   // Stage 3: running minimum.
   always_ff @(posedge clock) begin
      if (ctrl.init_best) begin
         best_ff <= COST_MAX;
      end else if (v2_ff && (cand < best_ff)) begin
         best_ff <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
      end
   end

   assign best = best_ff;
   assign busy = v1_ff | v2_ff;

`ifndef SYNTHESIS
   a_no_issue_and_write: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.issue && ctrl.write_best))
      else $error("cost table written while a split point is launched");
   a_no_init_midflight: assert property (@(posedge clock) disable iff (reset)
      ctrl.init_best |-> !v1_ff && !v2_ff)
      else $error("running minimum reset while the pipeline holds work");
   a_write_after_drain: assert property (@(posedge clock) disable iff (reset)
      ctrl.write_best |-> !busy)
      else $error("minimum stored before the pipeline drained");
`endif

endmodule

@@ rtl/matrix_chain_order_cost.sv @@
// ----------------------------------------------------------------------------
// matrix_chain_order_cost: minimum scalar-multiplication count of a chain
// Loads boundary dimensions one word at a time, then runs the interval
// dynamic program over a shared multiply/add/compare pipeline.
// ----------------------------------------------------------------------------
// A word not marked last is taken while the sequencer is idle. A last word that
// closes an error case or a single matrix goes straight to the emit state; a
// longer chain first runs the split loop over every interval.
// error cases and a single matrix raise the response valid from the emit state.
// The split-point loop issues one split per cycle, reading both sub-chain costs
// through the two read ports of the cost table; each interval also passes through
// its dimension reads and outer product before the loop, and the drain and table write after it.
// Reset (synchronous, active high) clears the dimension count, the overlong
// flag, the sequencer and the response valid; the stores need no clearing.
module matrix_chain_order_cost #(
   parameter int MAX_MATRICES = 16,
   parameter int DIM_WIDTH    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mcoc_pkg::mcoc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mcoc_pkg::mcoc_rsp_type rsp_data
);
   import mcoc_pkg::*;

   localparam int MAX_DIMS = MAX_MATRICES + 1;
   localparam int CNT_W    = $clog2(MAX_DIMS + 1);
   localparam int DADDR_W  = $clog2(MAX_DIMS);
   localparam int IDX_W    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;

   // Dimension store: written while loading, read once per cycle by the
   // sequencer with registered data.
   logic [DIM_WIDTH-1:0]   dim_mem [MAX_DIMS];
   logic [DIM_WIDTH-1:0]   dim_rd_ff;
   logic [DADDR_W-1:0]     dim_raddr;
   logic [DIM_WIDTH-1:0]   dim_in;

   mcoc_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   overlong_ff, overlong_in;
   logic [CNT_W-1:0]       mats_ff, mats_in;
   logic [CNT_W-1:0]       len_ff, len_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [DIM_WIDTH-1:0]   di_ff, di_in;
   logic [2*DIM_WIDTH-1:0] pij_ff, pij_in;
   logic [63:0]            res_cost_ff, res_cost_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mcoc_rsp_type           rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   dim_stored;
   logic [CNT_W-1:0]       new_count;
   logic                   chain_overlong;
   logic [IDX_W-1:0]       k_next;

   mcoc_eval_ctrl_type     eval_ctrl;
   logic [63:0]            eval_best;
   logic                   eval_busy;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign dim_in     = DIM_WIDTH'(req_data.dimension);
   assign dim_stored = (count_ff < CNT_W'(MAX_DIMS));
   assign new_count  = dim_stored ? (count_ff + CNT_W'(1)) : count_ff;
   assign chain_overlong = overlong_ff || !dim_stored;
   assign k_next     = k_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (req_accept && dim_stored) begin
         dim_mem[count_ff[DADDR_W-1:0]] <= dim_in;
      end
      dim_rd_ff <= dim_mem[dim_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overlong_in   = overlong_ff;
      mats_in       = mats_ff;
      len_in        = len_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      di_in         = di_ff;
      pij_in        = pij_ff;
      res_cost_in   = res_cost_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      dim_raddr     = DADDR_W'(i_ff);
      eval_ctrl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               count_in    = new_count;
               overlong_in = chain_overlong;
               if (req_data.last_dimension) begin
                  // The chain closes here; the store empties for the next one.
                  count_in    = '0;
                  overlong_in = 1'b0;
                  res_cost_in = '0;
                  mats_in     = new_count - CNT_W'(1);
                  len_in      = CNT_W'(2);
                  i_in        = '0;
                  j_in        = IDX_W'(1);
                  if (chain_overlong) begin
                     res_status_in = STATUS_TOO_MANY;
                     state_in      = ST_EMIT;
                  end else if (new_count < CNT_W'(2)) begin
                     res_status_in = STATUS_TOO_FEW;
                     state_in      = ST_EMIT;
                  end else if (new_count == CNT_W'(2)) begin
                     res_status_in = STATUS_OK;
                     state_in      = ST_EMIT;
                  end else begin
                     state_in = ST_DIM_I;
                  end
               end
            end
         end
         ST_DIM_I: begin
            dim_raddr = DADDR_W'(i_ff);
            state_in  = ST_DIM_J;
         end
         ST_DIM_J: begin
            dim_raddr = DADDR_W'(j_ff) + DADDR_W'(1);
            di_in     = dim_rd_ff;
            state_in  = ST_PROD;
         end
         ST_PROD: begin
            pij_in              = di_ff * dim_rd_ff;
            eval_ctrl.init_best = 1'b1;
            k_in                = i_ff;
            state_in            = ST_LOOP;
         end
         ST_LOOP: begin
            dim_raddr         = DADDR_W'(k_ff) + DADDR_W'(1);
            eval_ctrl.issue   = 1'b1;
            eval_ctrl.lo_diag = (k_ff == i_ff);
            eval_ctrl.hi_diag = (k_next == j_ff);
            if (k_next == j_ff) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_next;
            end
         end
         ST_DRAIN: begin
            if (!eval_busy) begin
               eval_ctrl.write_best = 1'b1;
               if (len_ff == mats_ff) begin
                  // The full-chain interval is the answer.
                  res_cost_in   = eval_best;
                  res_status_in = (eval_best == COST_MAX) ? STATUS_SAT : STATUS_OK;
                  state_in      = ST_EMIT;
               end else if ((CNT_W'(j_ff) + CNT_W'(1)) < mats_ff) begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_DIM_I;
               end else begin
                  len_in   = len_ff + CNT_W'(1);
                  i_in     = '0;
                  j_in     = IDX_W'(len_ff);
                  state_in = ST_DIM_I;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.min_cost = res_cost_ff;
               rsp_data_in.status   = res_status_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overlong_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overlong_ff  <= overlong_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mats_ff       <= mats_in;
      len_ff        <= len_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      di_ff         <= di_in;
      pij_ff        <= pij_in;
      res_cost_ff   <= res_cost_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   mcoc_eval_unit #(
      .DIM_WIDTH (DIM_WIDTH),
      .IDX_WIDTH (IDX_W)
   ) u_eval (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (eval_ctrl),
      .addr_lo    ({i_ff, k_ff}),
      .addr_hi    ({k_next, j_ff}),
      .addr_wr    ({i_ff, j_ff}),
      .outer_prod (pij_ff),
      .split_dim  (dim_rd_ff),
      .best       (eval_best),
      .busy       (eval_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_in_loop: assert property (@(posedge clock) disable iff (reset)
      eval_busy |-> (state_ff == ST_LOOP) || (state_ff == ST_DRAIN))
      else $error("evaluation pipeline active outside the split loop");
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_valid_ff && !rsp_ready |=>
      (state_ff == ST_EMIT) && rsp_valid_ff)
      else $error("result left the emit state while the output was full");
   a_error_zero_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_data_ff.status == STATUS_TOO_FEW) ||
      (rsp_data_ff.status == STATUS_TOO_MANY)) |-> (rsp_data_ff.min_cost == 64'd0))
      else $error("error result carries a nonzero cost");
   a_ok_not_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_OK) |->
      (rsp_data_ff.min_cost != COST_MAX))
      else $error("saturated cost reported as ok");
   a_split_below_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> (k_ff < j_ff) && (i_ff <= k_ff))
      else $error("split point outside its interval");
`endif

endmodule
